### rtl/eps_pkg.sv
// Shared types and constants for the prime sieve block.
// Used by eps_front, eps_queue, eps_back and the top level; no dependencies.
package eps_pkg;

	localparam int VAL_W       = 17;                      // candidate / limit width
	localparam int MAX_VALUE   = 131072;                  // bits in the composite map
	localparam int WORD_W      = 32;                      // map bits per memory word
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int MAP_WORDS   = MAX_VALUE / WORD_W;
	localparam int MAP_AW      = $clog2(MAP_WORDS);
	localparam int MARK_W      = VAL_W + 1;               // marking index, room for i + p
	localparam int SQ_W        = 2 * VAL_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int TDATA_W     = ((VAL_W + 7) / 8) * 8;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [MAP_AW-1:0] waddr_t;
	typedef logic [BIT_W-1:0]  bsel_t;
	typedef logic [MARK_W-1:0] mark_t;

	localparam val_t VAL_TWO = VAL_W'(2);

	// One classified item, front to back
	typedef struct packed {
		val_t cand;
		logic restart;
		logic order_err;
		logic in_range;
	} cmd_t;

	// Clamp the configured limit to the last map entry
	function automatic val_t eff_limit(val_t lim);
		if (int'(lim) > MAX_VALUE - 1) return VAL_W'(MAX_VALUE - 1);
		return lim;
	endfunction

	function automatic waddr_t word_of(mark_t idx);
		return MAP_AW'(idx >> BIT_W);
	endfunction

	function automatic bsel_t bit_of(mark_t idx);
		return idx[BIT_W-1:0];
	endfunction

endpackage

### rtl/eps_queue.sv
// Short command queue between the front and back parts of the prime sieve.
// Depends on eps_pkg (cmd_t, QUEUE_DEPTH).
module eps_queue import eps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic not_empty
);

	cmd_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

### rtl/eps_front.sv
// Front part of the prime sieve: limit register, order check and range check.
// Depends on eps_pkg; feeds eps_queue.
module eps_front import eps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  val_t               cfg_wr_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	input  logic               s_tuser,
	input  logic               q_full,
	input  logic               hold,
	output logic               push,
	output cmd_t               push_data,
	output val_t               eff_lim
);

	val_t expected_q;
	val_t lim_q;
	val_t cand;
	val_t exp_now;

	assign eff_lim  = lim_q;
	assign s_tready = !q_full && !hold;
	assign push     = s_tvalid && s_tready;

	assign cand    = s_tdata[VAL_W-1:0];
	assign exp_now = s_tuser ? VAL_TWO : expected_q;

	always_comb begin
		push_data.cand      = cand;
		push_data.restart   = s_tuser;
		push_data.order_err = (cand != exp_now);
		push_data.in_range  = (cand >= VAL_TWO) && (cand <= lim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= VAL_TWO;
			lim_q      <= eff_limit(VAL_TWO);
		end else begin
			if (cfg_wr_en) lim_q <= eff_limit(cfg_wr_data);
			// advance on an expected candidate; a restart rewinds even on mismatch
			if (push) begin
				if (cand == exp_now) expected_q <= cand + 1'b1;
				else if (s_tuser)    expected_q <= VAL_TWO;
			end
		end
	end

endmodule

### rtl/eps_back.sv
// Back part of the prime sieve: composite map memory, lookup, marking and result register.
// Depends on eps_pkg; drains eps_queue.
module eps_back import eps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  val_t eff_lim,
	input  logic q_valid,
	input  cmd_t q_data,
	output logic q_pop,
	input  logic out_ready,
	output logic out_valid,
	output val_t out_value,
	output logic out_prime,
	output logic out_oerr,
	output logic clearing
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_HANDLE = 6'b000100,
		ST_LOOK   = 6'b001000,
		ST_SQR    = 6'b010000,
		ST_MARK   = 6'b100000
	} state_t;

	state_t              state_q;
	waddr_t              clr_q;
	logic                pend_q;
	cmd_t                cur_q;
	logic [SQ_W-1:0]     sq_s1;
	mark_t               mark_q;
	logic                mk_v_s1;
	waddr_t              mk_word_s1;
	bsel_t               mk_bit_s1;
	logic                lw_v_q;
	waddr_t              lw_addr_q;
	logic [WORD_W-1:0]   lw_data_q;
	logic [WORD_W-1:0]   rdata_q;
	logic [WORD_W-1:0]   mem [MAP_WORDS];
	logic                out_valid_q;
	val_t                out_value_q;
	logic                out_prime_q;
	logic                out_oerr_q;

	logic                out_free;
	logic                issue;
	logic                out_set;
	logic                set_prime;
	logic                set_oerr;
	logic                hit;
	waddr_t              mem_raddr;
	logic                mem_we;
	waddr_t              mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic [WORD_W-1:0]   merged;
	mark_t               cand_ext;

	assign cand_ext  = MARK_W'(cur_q.cand);
	assign out_free  = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && out_free;
	assign issue     = (state_q == ST_MARK) && (mark_q <= MARK_W'(eff_lim));
	assign clearing  = (state_q == ST_CLEAR);
	assign hit       = rdata_q[bit_of(cand_ext)];
	assign mem_raddr = (state_q == ST_HANDLE) ? word_of(cand_ext) : word_of(mark_q);

	// forward the word written last cycle; the memory read did not see it
	assign merged = ((lw_v_q && (lw_addr_q == mk_word_s1)) ? lw_data_q : rdata_q)
	                | (WORD_W'(1) << mk_bit_s1);

	always_comb begin
		mem_we    = clearing || mk_v_s1;
		mem_waddr = clearing ? clr_q : mk_word_s1;
		mem_wdata = clearing ? '0 : merged;
	end

	always_comb begin
		out_set   = 1'b0;
		set_prime = 1'b0;
		set_oerr  = 1'b0;
		case (state_q)
			ST_HANDLE: begin
				if (cur_q.order_err || !cur_q.in_range) begin
					out_set  = 1'b1;
					set_oerr = cur_q.order_err;
				end
			end
			ST_LOOK: begin
				out_set   = 1'b1;
				set_prime = !hit;
			end
			default: begin
				out_set = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			mk_v_s1     <= 1'b0;
			lw_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mk_v_s1 <= issue;
			lw_v_q  <= mk_v_s1;
			if (out_set)        out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAP_AW'(MAP_WORDS - 1)) begin
						pend_q  <= 1'b0;
						state_q <= pend_q ? ST_HANDLE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						pend_q  <= q_data.restart;
						state_q <= q_data.restart ? ST_CLEAR : ST_HANDLE;
					end
				end
				ST_HANDLE: begin
					state_q <= out_set ? ST_IDLE : ST_LOOK;
				end
				ST_LOOK: begin
					state_q <= hit ? ST_IDLE : ST_SQR;
				end
				ST_SQR: begin
					state_q <= (sq_s1 <= SQ_W'(eff_lim)) ? ST_MARK : ST_IDLE;
				end
				ST_MARK: begin
					if (!issue && !mk_v_s1) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
		sq_s1      <= cur_q.cand * cur_q.cand;
		mk_word_s1 <= word_of(mark_q);
		mk_bit_s1  <= bit_of(mark_q);
		lw_addr_q  <= mk_word_s1;
		lw_data_q  <= merged;
		if (state_q == ST_SQR) mark_q <= MARK_W'(sq_s1);
		else if (issue)        mark_q <= mark_q + cand_ext;
		if (out_set) begin
			out_value_q <= cur_q.cand;
			out_prime_q <= set_prime;
			out_oerr_q  <= set_oerr;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_prime = out_prime_q;
	assign out_oerr  = out_oerr_q;

endmodule

### rtl/eratosthenes_prime_sieve.sv
// Top level of the streamed prime sieve.
// Depends on eps_pkg, eps_front, eps_queue and eps_back.
//
// Usage: candidates enter on the s_ channel in ascending order from 2, one per
// transfer; s_tuser set clears the map and rewinds the expected value to 2
// before that candidate is checked. Each transfer yields exactly one result on
// the m_ channel: the candidate, a prime flag and an order-error flag.
// cfg_wr_en/cfg_wr_data write the sieve limit; write it only while idle.
// Path: an accepted transfer passes the queue into the back; an out-of-order or
// out-of-range candidate is answered from the HANDLE state, a looked-up one
// from the LOOK state, through the result register. A composite candidate ends
// after LOOK; a prime p with p*p at or below the limit goes on through SQR and
// then walks the map at one marked multiple per cycle in MARK; the mark
// read-modify-write port of the map memory sets that rate. The back pops the next candidate only from IDLE.
// Reset: the 4096 words of the map memory are swept to zero, one word a cycle, with
// s_tready low; a restart transfer costs the same sweep. The limit resets to 2.
// Stall: the result register holds while m_tready is low; the front keeps
// taking candidates into a 4-entry queue until it fills, then drops s_tready.
module eratosthenes_prime_sieve import eps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [VAL_W-1:0]   cfg_wr_data,   // sieve_limit
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,       // [16:0] candidate, rest zero
	input  logic               s_tuser,       // [0] restart
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,       // [16:0] value, rest zero
	output logic [1:0]         m_tuser        // [0] is_prime, [1] order_error
);

	logic push;
	cmd_t push_data;
	logic q_full;
	logic q_valid;
	cmd_t q_data;
	logic q_pop;
	logic clearing;
	val_t eff_lim;
	val_t out_value;
	logic out_prime;
	logic out_oerr;

	// classify and check order at the input
	eps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.q_full      (q_full),
		.hold        (clearing),
		.push        (push),
		.push_data   (push_data),
		.eff_lim     (eff_lim)
	);

	// decouple the input from the marking walk
	eps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.not_empty (q_valid)
	);

	// look up, mark multiples, hold the result
	eps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_lim   (eff_lim),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (out_value),
		.out_prime (out_prime),
		.out_oerr  (out_oerr),
		.clearing  (clearing)
	);

	assign m_tdata = TDATA_W'(out_value);
	assign m_tuser = {out_oerr, out_prime};

`ifndef NO_ASSERTIONS
	// an out-of-order candidate is never reported prime
	a_oerr_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("order error reported together with prime");

	// primes start at two
	a_prime_min: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (out_value >= VAL_TWO))
		else $error("value below two reported prime");

	// queue occupancy stays consistent
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && !q_valid))
		else $error("queue full and empty at once");

	// the back only pops from a non-empty queue and while the map is not being swept
	a_pop_not_clear: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && !clearing))
		else $error("pop during map sweep or from empty queue");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for eratosthenes_prime_sieve: a directed stimulus table and
// randomized pacing phases, scored against typed answers or an in-bench sieve.
// Depends on eps_pkg and the RTL top level only.
module testbench;
	import eps_pkg::*;

	localparam int          HALF_NS      = 6;
	localparam int          RESET_CYCLES = 7;
	localparam int          DRAIN_CYCLES = 16;          // idle margin after the last expected result
	localparam int          HOLD_CYCLES  = 400;         // long receiver hold-off, fills the queue
	localparam int          PHASE_ITEMS  = 165;         // in-order transfers per random phase
	localparam int unsigned WATCHDOG_NS  = 60_000_000;  // overall time limit for the run
	localparam val_t        VAL_MAX      = '1;

	typedef struct packed {
		val_t value;
		logic is_prime;
		logic order_error;
	} sieve_res_t;

	typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_e;

	typedef struct {
		row_kind_e  kind;
		val_t       data;      // candidate, or the new sieve limit
		logic       restart;
		logic       typed;     // answer typed into the row instead of predicted
		sieve_res_t answer;
	} stim_row_t;

	// DUT ports; the bench-driven inputs are known from time zero
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [VAL_W-1:0]   cfg_wr_data = '0;
	logic               s_tvalid    = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata     = '0;   // [16:0] candidate, rest zero
	logic               s_tuser     = 1'b0; // [0] restart
	logic               m_tvalid;
	logic               m_tready    = 1'b0;
	logic [TDATA_W-1:0] m_tdata;            // [16:0] value, rest zero
	logic [1:0]         m_tuser;            // [0] is_prime, [1] order_error

	// Row tag that travels with the offered transfer
	logic       offer_typed  = 1'b0;
	sieve_res_t offer_answer = '0;

	// Sieve state as the bench predicts it
	bit [MAX_VALUE-1:0] composite_bits = '0;
	val_t               want_next      = VAL_TWO;
	val_t               sieve_cap      = VAL_TWO;
	sieve_res_t         answer_q[$];

	// Sender-side view of the next in-order candidate
	val_t seq_next = VAL_TWO;

	stim_row_t directed_rows[$];

	int          src_idle_pct   = 0;
	int          sink_stall_pct = 0;
	logic        hold_req       = 1'b0;
	bit          hold_taken     = 1'b0;
	int          hold_left      = 0;
	int unsigned fail_count     = 0;
	int unsigned n_items        = 0;
	int unsigned n_results      = 0;
	int unsigned n_restarts     = 0;
	int unsigned n_primes       = 0;
	int unsigned n_order_errors = 0;

	eratosthenes_prime_sieve u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always begin
		#HALF_NS clk = 1'b1;
		#HALF_NS clk = 1'b0;
	end

	// Classify one accepted candidate and advance the sieve; a prime marks its
	// multiples from p*p up to the clamped limit right away.
	function automatic sieve_res_t classify_candidate(val_t cand, logic restart);
		sieve_res_t      res;
		longint unsigned cap;
		res = '{value: cand, is_prime: 1'b0, order_error: 1'b0};
		if (restart) begin
			composite_bits = '0;
			want_next      = VAL_TWO;
		end
		if (cand != want_next) begin
			res.order_error = 1'b1;
			return res;
		end
		want_next = want_next + 1'b1;   // wraps at the 17-bit width
		cap = (sieve_cap > MAX_VALUE - 1) ? MAX_VALUE - 1 : sieve_cap;
		if (cand >= VAL_TWO && cand <= cap && !composite_bits[cand]) begin
			res.is_prime = 1'b1;
			for (longint unsigned m = longint'(cand) * cand; m <= cap; m += cand)
				composite_bits[val_t'(m)] = 1'b1;
		end
		return res;
	endfunction

	function automatic stim_row_t item_row(val_t cand, logic restart, logic typed = 1'b0,
			logic prime = 1'b0, logic err = 1'b0);
		stim_row_t row;
		row.kind    = ROW_ITEM;
		row.data    = cand;
		row.restart = restart;
		row.typed   = typed;
		row.answer  = '{value: cand, is_prime: prime, order_error: err};
		return row;
	endfunction

	function automatic stim_row_t limit_row(val_t lim);
		stim_row_t row;
		row      = item_row(lim, 1'b0);
		row.kind = ROW_LIMIT;
		return row;
	endfunction

	// Append one row to the directed table
	function automatic void add_row(stim_row_t row);
		directed_rows = {directed_rows, row};
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Offer one transfer, with random idle cycles first, and hold it until accepted.
	// Valid stays high on return so back-to-back transfers need no toggle.
	task automatic offer_item(val_t cand, logic restart, logic typed, sieve_res_t answer);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid     <= 1'b1;
		s_tdata      <= TDATA_W'(cand);
		s_tuser      <= restart;
		offer_typed  <= typed;
		offer_answer <= answer;
		do @(posedge clk); while (!s_tready);
		if (restart)
			seq_next = VAL_TWO;
		if (cand == seq_next)
			seq_next = seq_next + 1'b1;
	endtask

	// Bring the block to idle. Close with an out-of-order transfer: its result
	// cannot overtake a multiple-marking walk still under way.
	task automatic settle();
		offer_item(seq_next + 1'b1, 1'b0, 1'b0, '0);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (answer_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(val_t lim);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= lim;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sieve_cap = lim;
	endtask

	// Predict every accepted input transfer
	always @(posedge clk) begin : input_monitor
		sieve_res_t res;
		if (arst_n && s_tvalid && s_tready) begin
			res = classify_candidate(s_tdata[VAL_W-1:0], s_tuser);
			answer_q = {answer_q, (offer_typed ? offer_answer : res)};
			n_items++;
			if (s_tuser)
				n_restarts++;
			if (res.is_prime)
				n_primes++;
			if (res.order_error)
				n_order_errors++;
		end
	end

	// Score every result transfer against the oldest expectation
	always @(posedge clk) begin : result_monitor
		sieve_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (answer_q.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected: expected none, actual value %0d",
					$time, m_tdata[VAL_W-1:0]);
			end else begin
				want = answer_q.pop_front();
				check_field("value", want.value, m_tdata[VAL_W-1:0]);
				check_field("is_prime", want.is_prime, m_tuser[0]);
				check_field("order_error", want.order_error, m_tuser[1]);
			end
		end
	end

	// Receiver pacing; one long hold-off when requested, counted here
	always @(posedge clk) begin : result_sink
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("%0t: timeout with %0d results outstanding", $time, answer_q.size());
		$display("eratosthenes_prime_sieve regression: fail");
		$finish;
	end

	initial begin : stimulus
		val_t        cand;
		logic        restart;
		int unsigned roll;
		int          good;
		val_t        lim;

		// Limit 2 out of reset: 2 is the only prime, no marking
		add_row(item_row(VAL_TWO, 1'b0, 1'b1, 1'b1, 1'b0));
		add_row(item_row(val_t'(3), 1'b0, 1'b1, 1'b0, 1'b0));        // above limit
		add_row(item_row(val_t'(0), 1'b0, 1'b1, 1'b0, 1'b1));        // out of order
		add_row(item_row(VAL_MAX, 1'b0, 1'b1, 1'b0, 1'b1));          // out of order
		add_row(item_row(val_t'(4), 1'b0, 1'b1, 1'b0, 1'b0));
		// Lowest limit: nothing is prime
		add_row(limit_row(val_t'(0)));
		add_row(item_row(VAL_TWO, 1'b1, 1'b1, 1'b0, 1'b0));
		add_row(item_row(val_t'(1), 1'b1, 1'b1, 1'b0, 1'b1));        // restart, mismatch
		add_row(item_row(VAL_TWO, 1'b0, 1'b1, 1'b0, 1'b0));          // still expects 2
		// Highest limit: 2 and 3 walk the whole map
		add_row(limit_row(VAL_MAX));
		add_row(item_row(VAL_TWO, 1'b1, 1'b1, 1'b1, 1'b0));
		add_row(item_row(val_t'(3), 1'b0, 1'b1, 1'b1, 1'b0));
		add_row(item_row(val_t'(4), 1'b0, 1'b1, 1'b0, 1'b0));
		// Limit lowered mid-run without restart: the map stands as it is
		add_row(limit_row(val_t'(30)));
		add_row(item_row(val_t'(5), 1'b0));
		add_row(item_row(val_t'(6), 1'b0));
		add_row(item_row(val_t'(7), 1'b0));
		add_row(limit_row(val_t'(1)));
		add_row(item_row(VAL_TWO, 1'b1, 1'b1, 1'b0, 1'b0));
		add_row(limit_row(val_t'(100)));
		add_row(item_row(VAL_TWO, 1'b1));
		for (int v = 3; v <= 5; v++)
			add_row(item_row(val_t'(v), 1'b0));
		add_row(item_row(val_t'(9), 1'b0, 1'b1, 1'b0, 1'b1));        // skips ahead
		for (int v = 6; v <= 9; v++)
			add_row(item_row(val_t'(v), 1'b0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; limit rows only apply once the block is idle
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_LIMIT) begin
				settle();
				write_limit(directed_rows[i].data);
			end else begin
				offer_item(directed_rows[i].data, directed_rows[i].restart,
					directed_rows[i].typed, directed_rows[i].answer);
			end
		end

		// Random phases: mostly in-order runs, some restarts, some strays
		for (int mode = 0; mode < 4; mode++) begin
			settle();
			case (mode)
				0: begin
					src_idle_pct    = 0;
					sink_stall_pct <= 0;
					lim             = val_t'($urandom_range(300, 3000));
				end
				1: begin
					src_idle_pct    = 63;
					sink_stall_pct <= 0;
					lim             = val_t'($urandom_range(2, 60));
				end
				2: begin
					src_idle_pct    = 0;
					sink_stall_pct <= 63;
					lim             = val_t'($urandom_range(1000, 4000));
				end
				default: begin
					src_idle_pct    = 33;
					sink_stall_pct <= 33;
					lim             = val_t'($urandom_range(64, 400));
				end
			endcase
			write_limit(lim);
			// Hold the receiver off while the sender keeps pushing
			if (mode == 0)
				hold_req <= 1'b1;
			good = 0;
			while (good < PHASE_ITEMS) begin
				roll    = $urandom_range(99);
				restart = 1'b0;
				cand    = seq_next;
				if (roll < 3) begin
					restart = 1'b1;
					cand    = ($urandom_range(3) == 0) ? val_t'($urandom) : VAL_TWO;
				end else if (roll < 8) begin
					cand = val_t'($urandom);
				end else if (roll < 12) begin
					cand = ($urandom_range(1) == 0) ? seq_next - 1'b1
						: seq_next + val_t'($urandom_range(1, 2));
				end
				if (restart ? cand == VAL_TWO : cand == seq_next)
					good++;
				offer_item(cand, restart, 1'b0, '0);
			end
		end

		// Drain the last results, then allow for anything stray
		s_tvalid <= 1'b0;
		do @(posedge clk); while (answer_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transfers and %0d results: %0d restarts, %0d order errors, %0d primes.",
			n_items, n_results, n_restarts, n_order_errors, n_primes);
		$display("Directed rows over the limit edges and four pacing phases with a long hold.");
		if (fail_count == 0) begin
			$display("eratosthenes_prime_sieve regression: pass");
		end else begin
			$display("eratosthenes_prime_sieve regression: fail");
		end
		$finish;
	end

endmodule
